/* rtl/core/scf_pkg.sv */
// Shared constants, codes and helper functions for the sine soft clipper.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package scf_pkg;

    // Default audio sample width and fixed register widths
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int GAIN_W           = 24;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    // Clip threshold: level * round(pi/2 * 2^30), rounded back by 14 bits
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int          COMP_SHIFT  = 14;

    // Unsigned Q2.62 arithmetic of the sine series
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

    // Phase divider: 63 quotient bits, the first 17 of them the integer part
    localparam int QBITS        = 63;
    localparam int DIV_PRESHIFT = 17;
    localparam int DIV_STAGES   = 9;
    localparam int DIV_STEPS    = 7;

    // Horner series and the digit-serial constant dividers inside it
    localparam int HORNER_TERMS = 12;
    localparam int DIGIT_W      = 16;
    localparam int DIGITS       = 4;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int   CFG_ADDR_W = 3;
    localparam logic REG_GAIN   = 1'b0;
    localparam logic REG_LEVEL  = 1'b1;

    // How a sample is handled by the back
    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_CLIP = 2'd1;
    localparam logic [1:0] KIND_SINE = 2'd2;

    // Divisor (2k)(2k+1) of Horner step i, where k counts down from the top term
    function automatic int horner_div(input int i);
        int k;
        k = HORNER_TERMS - i;
        return (2 * k) * (2 * k + 1);
    endfunction

endpackage

/* rtl/core/scf_front.sv */
// Front of the sine soft clipper: takes samples, applies the drive gain and
// classifies each one as zero, clipped or sine-shaped. Uses scf_pkg.
`timescale 1ns / 1ps

module scf_front #(
    parameter int SW = scf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_vld,
    output logic                                in_rdy,
    input  logic signed [SW-1:0]                sample,
    input  logic                                fe,
    input  logic [scf_pkg::GAIN_W-1:0]          gain,
    input  logic [SW-2:0]                       lvl,
    input  logic [SW+15:0]                      comp,
    output logic                                q_push,
    input  logic                                q_full,
    output logic [SW+27:0]                      q_item
);
    import scf_pkg::*;

    localparam int YW = SW + 24;
    localparam int IW = YW + 4;

    logic             front_en;
    logic [SW-1:0]    raw;
    logic [SW-1:0]    x_abs;
    logic             a_vld_reg;
    logic             a_neg_reg;
    logic             a_fe_reg;
    logic [YW-1:0]    a_y_reg;
    logic [1:0]       kind;
    logic             b_vld_reg;
    logic [IW-1:0]    b_item_reg;

    // Both stages move together whenever the last one can hand its request on
    assign front_en = !b_vld_reg || !q_full;
    assign in_rdy   = front_en;
    assign q_push   = b_vld_reg && !q_full;
    assign q_item   = b_item_reg;

    // Magnitude of the sample; the most negative code maps to 2^(SW-1)
    assign raw   = sample;
    assign x_abs = raw[SW-1] ? SW'(~raw + 1'b1) : raw;

    // Stage A: apply the drive gain, exact product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (front_en)
        begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            a_neg_reg <= raw[SW-1];
            a_fe_reg  <= fe;
            a_y_reg   <= YW'(x_abs) * YW'(gain);
        end
    end

    // Classification against the level and the clip threshold
    always_comb
    begin
        if (lvl == '0 || a_y_reg == '0)
        begin
            kind = KIND_ZERO;
        end
        else if (a_y_reg > YW'(comp))
        begin
            kind = KIND_CLIP;
        end
        else
        begin
            kind = KIND_SINE;
        end
    end

    // Stage B: classified request waiting for the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (front_en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            b_item_reg <= {kind, a_neg_reg, a_fe_reg, a_y_reg};
        end
    end

endmodule

/* rtl/core/scf_fifo.sv */
// Short request queue between the front and the back of the clipper.
// Takes its default depth from scf_pkg.
`timescale 1ns / 1ps

module scf_fifo #(
    parameter int W     = 52,
    parameter int DEPTH = scf_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_vld,
    output logic [W-1:0] head_data
);
    import scf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign head_vld  = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && head_vld;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/scf_mulq.sv */
// Two-stage Q2.62 multiplier: four 32x32 partial products, then the sum
// and the bit window [125:62], optionally rounded. Uses scf_pkg.
`timescale 1ns / 1ps

module scf_mulq #(
    parameter int SIDE_W = 4,
    parameter bit ROUND  = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [63:0]       p,
    output logic [SIDE_W-1:0] side_out
);
    import scf_pkg::*;

    logic              v1_reg;
    logic [63:0]       pp00_reg;
    logic [63:0]       pp01_reg;
    logic [63:0]       pp10_reg;
    logic [63:0]       pp11_reg;
    logic [SIDE_W-1:0] s1_reg;
    logic [127:0]      sum;
    logic              v2_reg;
    logic [63:0]       p_reg;
    logic [SIDE_W-1:0] s2_reg;

    // Valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    // Partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            pp01_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            pp10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            pp11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            s1_reg   <= side_in;
        end
    end

    // Full product, with half an LSB of the result added when rounding
    assign sum = 128'(pp00_reg) + (128'(pp01_reg) << 32) + (128'(pp10_reg) << 32)
               + {pp11_reg, 64'd0} + (128'(ROUND) << 61);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= sum[125:62];
            s2_reg <= s1_reg;
        end
    end

    assign out_vld  = v2_reg;
    assign p        = p_reg;
    assign side_out = s2_reg;

endmodule

/* rtl/core/scf_divc.sv */
// Pipelined division of a 64-bit value by a small constant, one 16-bit digit
// per two stages (reciprocal estimate, then remainder and correction). Uses scf_pkg.
`timescale 1ns / 1ps

module scf_divc #(
    parameter int C      = 6,
    parameter int SIDE_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [63:0]       v,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [63:0]       q,
    output logic [SIDE_W-1:0] side_out
);
    import scf_pkg::*;

    localparam int          RW    = $clog2(C);
    localparam int          TW    = RW + 1;
    localparam int          NW    = RW + DIGIT_W;
    localparam logic [31:0] DIV_M = 32'((64'd1 << 32) / C);

    logic              a_vld_reg  [DIGITS];
    logic [NW-1:0]     a_n_reg    [DIGITS];
    logic [DIGIT_W-1:0] a_qe_reg  [DIGITS];
    logic [63:0]       a_vq_reg   [DIGITS];
    logic [SIDE_W-1:0] a_side_reg [DIGITS];
    logic              b_vld_reg  [DIGITS];
    logic [RW-1:0]     b_r_reg    [DIGITS];
    logic [63:0]       b_vq_reg   [DIGITS];
    logic [SIDE_W-1:0] b_side_reg [DIGITS];

    for (genvar j = 0; j < DIGITS; j++)
    begin : g_digit
        logic              src_vld;
        logic [RW-1:0]     src_r;
        logic [63:0]       src_vq;
        logic [SIDE_W-1:0] src_side;
        logic [NW-1:0]     n_next;
        logic [NW+31:0]    prod;
        logic [TW-1:0]     t;
        logic [DIGIT_W-1:0] qd;
        logic [RW-1:0]     r_next;

        if (j == 0)
        begin : g_first
            assign src_vld  = in_vld;
            assign src_r    = '0;
            assign src_vq   = v;
            assign src_side = side_in;
        end
        else
        begin : g_next
            assign src_vld  = b_vld_reg[j-1];
            assign src_r    = b_r_reg[j-1];
            assign src_vq   = b_vq_reg[j-1];
            assign src_side = b_side_reg[j-1];
        end

        // Estimate: low by at most one
        assign n_next = {src_r, src_vq[63 -: DIGIT_W]};
        assign prod   = (NW + 32)'(n_next) * (NW + 32)'(DIV_M);

        // Remainder below twice the divisor, one correction step
        assign t = TW'(a_n_reg[j] - NW'(32'(a_qe_reg[j]) * 32'(C)));

        always_comb
        begin
            if (t >= TW'(C))
            begin
                qd     = a_qe_reg[j] + 1'b1;
                r_next = RW'(t - TW'(C));
            end
            else
            begin
                qd     = a_qe_reg[j];
                r_next = RW'(t);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg[j] <= 1'b0;
                b_vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                a_vld_reg[j] <= src_vld;
                b_vld_reg[j] <= a_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_n_reg[j]    <= n_next;
                a_qe_reg[j]   <= prod[DIGIT_W+31:32];
                a_vq_reg[j]   <= src_vq;
                a_side_reg[j] <= src_side;
                b_r_reg[j]    <= r_next;
                b_vq_reg[j]   <= {a_vq_reg[j][63-DIGIT_W:0], qd};
                b_side_reg[j] <= a_side_reg[j];
            end
        end
    end

    assign out_vld  = b_vld_reg[DIGITS-1];
    assign q        = b_vq_reg[DIGITS-1];
    assign side_out = b_side_reg[DIGITS-1];

endmodule

/* rtl/core/scf_back.sv */
// Back of the sine soft clipper: phase divider, Horner sine series, level
// scaling and the output register. Uses scf_pkg, scf_mulq and scf_divc.
`timescale 1ns / 1ps

module scf_back #(
    parameter int SW = scf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_vld,
    input  logic [SW+27:0] q_data,
    output logic           q_pop,
    input  logic [SW-2:0]  lvl,
    output logic           out_vld,
    input  logic           out_rdy,
    output logic [SW-1:0]  out_sample,
    output logic           out_fe
);
    import scf_pkg::*;

    localparam int LW = SW - 1;
    localparam int YW = SW + 24;
    localparam int SB = 4;
    localparam int SX = SB + 64;
    localparam int SH = SB + 128;

    typedef struct packed {
        logic             vld;
        logic             neg;
        logic             fe;
        logic [1:0]       kind;
        logic [LW-1:0]    rem;
        logic [QBITS-1:0] dq;
    } dv_t;

    logic           en;
    dv_t            dv_reg [DIV_STAGES];
    logic [63:0]    x_ang;
    logic [SB-1:0]  base;
    logic           x2_vld;
    logic [63:0]    x2;
    logic [SX-1:0]  x2_side;
    logic           h_vld  [HORNER_TERMS+1];
    logic [63:0]    h_val  [HORNER_TERMS+1];
    logic [SH-1:0]  h_side [HORNER_TERMS+1];
    logic           s_vld;
    logic [63:0]    s_val;
    logic [SB-1:0]  s_side;
    logic           m_vld;
    logic [63:0]    m_val;
    logic [SB-1:0]  m_side;
    logic [LW-1:0]  mag;
    logic           out_vld_reg;
    logic [SW-1:0]  out_sample_reg;
    logic           out_fe_reg;

    // The whole back moves one step whenever the output register is free
    assign en    = !out_vld_reg || out_rdy;
    assign q_pop = en && q_vld;

    // Phase divider: |y| / level, seven restoring steps per stage
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        dv_t           src;
        dv_t           nxt;
        logic [LW:0]   r2;

        if (j == 0)
        begin : g_load
            // Integer bits above the preshift are known to be below the level
            assign src.vld  = q_vld;
            assign src.kind = q_data[YW+3:YW+2];
            assign src.neg  = q_data[YW+1];
            assign src.fe   = q_data[YW];
            assign src.rem  = q_data[LW+DIV_PRESHIFT-1:DIV_PRESHIFT];
            assign src.dq   = {q_data[DIV_PRESHIFT-1:0], {(QBITS - DIV_PRESHIFT){1'b0}}};
        end
        else
        begin : g_chain
            assign src = dv_reg[j-1];
        end

        always_comb
        begin
            nxt = src;
            r2  = '0;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                r2 = {nxt.rem, nxt.dq[QBITS-1]};
                if (r2 >= {1'b0, lvl})
                begin
                    nxt.rem = LW'(r2 - {1'b0, lvl});
                    nxt.dq  = {nxt.dq[QBITS-2:0], 1'b1};
                end
                else
                begin
                    nxt.rem = r2[LW-1:0];
                    nxt.dq  = {nxt.dq[QBITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= '0;
            end
            else if (en)
            begin
                dv_reg[j] <= nxt;
            end
        end
    end

    assign x_ang = {1'b0, dv_reg[DIV_STAGES-1].dq};
    assign base  = {dv_reg[DIV_STAGES-1].neg, dv_reg[DIV_STAGES-1].fe,
                    dv_reg[DIV_STAGES-1].kind};

    // Square of the angle
    scf_mulq #(.SIDE_W(SX), .ROUND(1'b0)) u_sq (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (dv_reg[DIV_STAGES-1].vld),
        .a        (x_ang),
        .b        (x_ang),
        .side_in  ({x_ang, base}),
        .out_vld  (x2_vld),
        .p        (x2),
        .side_out (x2_side)
    );

    assign h_vld[0]  = x2_vld;
    assign h_val[0]  = ONE_Q62;
    assign h_side[0] = {x2, x2_side};

    // Horner series: h = 1 - x^2 * h / ((2k)(2k+1)), top term first
    for (genvar i = 0; i < HORNER_TERMS; i++)
    begin : g_horner
        logic          t_vld;
        logic [63:0]   t_val;
        logic [SH-1:0] t_side;
        logic          d_vld;
        logic [63:0]   d_q;
        logic [SH-1:0] d_side;

        scf_mulq #(.SIDE_W(SH), .ROUND(1'b0)) u_mul (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (h_vld[i]),
            .a        (h_side[i][SH-1:SX]),
            .b        (h_val[i]),
            .side_in  (h_side[i]),
            .out_vld  (t_vld),
            .p        (t_val),
            .side_out (t_side)
        );

        scf_divc #(.C(horner_div(i)), .SIDE_W(SH)) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (t_vld),
            .v        (t_val),
            .side_in  (t_side),
            .out_vld  (d_vld),
            .q        (d_q),
            .side_out (d_side)
        );

        assign h_vld[i+1]  = d_vld;
        assign h_val[i+1]  = ONE_Q62 - d_q;
        assign h_side[i+1] = d_side;
    end

    // Sine = x * h
    scf_mulq #(.SIDE_W(SB), .ROUND(1'b0)) u_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (h_vld[HORNER_TERMS]),
        .a        (h_side[HORNER_TERMS][SX-1:SB]),
        .b        (h_val[HORNER_TERMS]),
        .side_in  (h_side[HORNER_TERMS][SB-1:0]),
        .out_vld  (s_vld),
        .p        (s_val),
        .side_out (s_side)
    );

    // Scale by the level, rounded to the nearest LSB
    scf_mulq #(.SIDE_W(SB), .ROUND(1'b1)) u_lvl (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_vld),
        .a        (64'(lvl)),
        .b        (s_val),
        .side_in  (s_side),
        .out_vld  (m_vld),
        .p        (m_val),
        .side_out (m_side)
    );

    // Magnitude by kind; the sine result never exceeds the level
    always_comb
    begin
        case (m_side[1:0])
            KIND_CLIP:
            begin
                mag = lvl;
            end
            KIND_SINE:
            begin
                mag = (m_val > 64'(lvl)) ? lvl : m_val[LW-1:0];
            end
            default:
            begin
                mag = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= m_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_sample_reg <= m_side[3] ? SW'(~{1'b0, mag} + 1'b1) : SW'({1'b0, mag});
            out_fe_reg     <= m_side[2];
        end
    end

    assign out_vld    = out_vld_reg;
    assign out_sample = out_sample_reg;
    assign out_fe     = out_fe_reg;

endmodule

/* rtl/core/sine_soft_clipper.sv */
// Sine soft clipper, top level: configuration port, front, request queue, back.
// Depends on scf_pkg, scf_front, scf_fifo and scf_back.
`timescale 1ns / 1ps

// Takes one signed sample per cycle while s_tready is high, multiplies it by
// the drive gain and returns level*sin(y/level), or +/-level beyond the clip
// threshold; tlast is carried through. Throughput is one sample per clock
// cycle when the output is taken every cycle. The pipeline holds the phase
// divider (9 stages) and the twelve-term sine series, each term one 2-stage
// multiplier and one 8-stage constant divider. A four-entry queue between the
// front and the back lets either side stall without stopping the other.
module sine_soft_clipper #(
    parameter int SAMPLE_WIDTH = scf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // sample_in
    input  logic                                      s_tlast,   // frame_end
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,   // sample_out
    output logic                                      m_tlast,   // frame_end_out
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [scf_pkg::CFG_ADDR_W-1:0]            paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);
    import scf_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int LW  = SW - 1;
    localparam int TDW = ((SW + 7) / 8) * 8;
    localparam int CW  = LW + 17;
    localparam int PW  = LW + 32;
    localparam int IW  = SW + 28;

    logic              cfg_wr;
    logic              reg_idx;
    logic [GAIN_W-1:0] gain_reg;
    logic [LW-1:0]     level_reg;
    logic [CW-1:0]     comp_reg;
    logic              q_push;
    logic              q_full;
    logic [IW-1:0]     q_item;
    logic              q_pop;
    logic              q_vld;
    logic [IW-1:0]     q_head;
    logic [SW-1:0]     out_sample;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            level_reg <= '1;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_GAIN:
                begin
                    gain_reg <= pwdata[GAIN_W-1:0];
                end
                REG_LEVEL:
                begin
                    level_reg <= pwdata[LW-1:0];
                end
                default:
                begin
                    gain_reg <= gain_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAIN:  prdata = 32'(gain_reg);
            REG_LEVEL: prdata = 32'(level_reg);
            default:   prdata = '0;
        endcase
    end

    // Clip threshold in units of the gained sample, refreshed every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg <= '0;
        end
        else
        begin
            comp_reg <= CW'((PW'(level_reg) * PW'(HALF_PI_Q30)
                             + (PW'(1) << (COMP_SHIFT - 1))) >> COMP_SHIFT);
        end
    end

    scf_front #(.SW(SW)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s_tvalid),
        .in_rdy  (s_tready),
        .sample  ($signed(s_tdata[SW-1:0])),
        .fe      (s_tlast),
        .gain    (gain_reg),
        .lvl     (level_reg),
        .comp    (comp_reg),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_item  (q_item)
    );

    scf_fifo #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_vld  (q_vld),
        .head_data (q_head)
    );

    scf_back #(.SW(SW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_vld      (q_vld),
        .q_data     (q_head),
        .q_pop      (q_pop),
        .lvl        (level_reg),
        .out_vld    (m_tvalid),
        .out_rdy    (m_tready),
        .out_sample (out_sample),
        .out_fe     (m_tlast)
    );

    assign m_tdata = TDW'(out_sample);

`ifndef SYNTHESIS
    // The front never offers a request to a full queue.
    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into a full queue");

    // Input back-pressure comes only from a full queue.
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_full)
        else $error("input stalled while the queue had room");

    // A request that reaches the back while it can move is taken at once.
    a_pop_taken : assert property (@(posedge clk) disable iff (!rst_n)
        (q_vld && (!m_tvalid || m_tready)) |-> q_pop)
        else $error("back idle while a request waited");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for sine_soft_clipper: stream stimulus, APB register writes
// and a bit-exact fixed-point predictor of the shaped output. Depends on scf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import scf_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int DW = ((SW + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 250;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          last;
    } shaped_t;

    typedef struct {
        logic [SW-1:0] sample;
        logic          last;
        logic          known;
        logic [SW-1:0] shaped;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;
    logic          s_tlast;
    logic          m_tvalid;
    logic          m_tready;
    logic [DW-1:0] m_tdata;
    logic          m_tlast;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Shadow copy of the registers and the store of shaped samples still awaited
    logic [63:0]   gain_shadow;
    logic [63:0]   level_shadow;
    shaped_t       pending_shaped[$];
    int            fail_count;
    int            cycle_count;
    logic          no_stalls;

    sine_soft_clipper uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Q2.62 product, truncated
    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Twelve-term Horner series for sin of a Q2.62 angle
    function automatic logic [63:0] sine_series(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] h;
        int          k;
        x2 = q62_product(x, x);
        h = ONE_Q62;
        for (k = 12; k >= 1; k--)
            h = ONE_Q62 - q62_product(x2, h) / 64'((2 * k) * (2 * k + 1));
        return q62_product(x, h);
    endfunction

    // Expected shaped sample for the current gain and level
    function automatic logic [SW-1:0] shaped_sample(input logic [SW-1:0] x,
                                                    input logic [63:0] g,
                                                    input logic [63:0] l);
        logic         neg;
        logic [63:0]  x_abs;
        logic [63:0]  y_abs;
        logic [63:0]  comp;
        logic [63:0]  q;
        logic [63:0]  rem;
        logic [63:0]  mag;
        logic [127:0] p;
        int           i;
        neg = x[SW-1];
        x_abs = neg ? (64'd1 << SW) - {{(64-SW){1'b0}}, x} : {{(64-SW){1'b0}}, x};
        y_abs = x_abs * g;
        mag = 64'd0;
        if (l != 0 && y_abs != 0)
        begin
            comp = (l * {33'd0, HALF_PI_Q30} + 64'd8192) >> COMP_SHIFT;
            if (y_abs > comp)
                mag = l;
            else
            begin
                q = y_abs / l;
                rem = y_abs % l;
                for (i = 0; i < 46; i++)
                begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= l)
                    begin
                        rem = rem - l;
                        q[0] = 1'b1;
                    end
                end
                p = {64'd0, l} * {64'd0, sine_series(q)};
                p = p + (128'd1 << 61);
                mag = p[125:62];
                if (mag > l)
                    mag = l;
            end
        end
        return neg ? SW'(64'd0 - mag) : mag[SW-1:0];
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Output side: check each accepted result, then pick the next ready value
    initial
    begin
        int stall_left;
        shaped_t exp_item;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_shaped.size() == 0)
                begin
                    $error("unexpected result: sample_out=%h frame_end_out=%b",
                           m_tdata[SW-1:0], m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_item = pending_shaped.pop_front();
                    if (m_tdata[SW-1:0] !== exp_item.sample)
                    begin
                        $error("sample_out: expected %h, got %h", exp_item.sample,
                               m_tdata[SW-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_item.last)
                    begin
                        $error("frame_end_out: expected %b, got %b", exp_item.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!no_stalls && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one request and hold it until it is taken
    task automatic send_request(input logic [SW-1:0] sample, input logic last,
                                input logic known, input logic [SW-1:0] shaped);
        int      gap;
        shaped_t exp_item;
        gap = 0;
        if (!no_stalls && $urandom_range(0, 99) < 30)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(DW-SW){1'b0}}, sample};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        exp_item.sample = shaped_sample(sample, gain_shadow, level_shadow);
        exp_item.last = last;
        if (known && shaped !== exp_item.sample)
        begin
            $error("sample_out: table expects %h, predictor gives %h", shaped, exp_item.sample);
            fail_count++;
        end
        pending_shaped.push_back(exp_item);
    endtask

    // Wait until every result is back and the pipeline has emptied
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_shaped.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of one register, then a read back of the stored value
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] stored;
        if (idx == REG_GAIN)
        begin
            gain_shadow = {40'd0, value[GAIN_W-1:0]};
            stored = 32'(gain_shadow);
        end
        else
        begin
            level_shadow = {{(64-SW+1){1'b0}}, value[SW-2:0]};
            stored = 32'(level_shadow);
        end
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored)
        begin
            $error("prdata: expected %h, got %h", stored, prdata);
            fail_count++;
        end
        if (pready !== 1'b1)
        begin
            $error("pready: expected %b, got %b", 1'b1, pready);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random sample: full range, small values, or close to the clip threshold
    function automatic logic [SW-1:0] random_sample();
        logic [63:0] comp;
        logic [63:0] mag;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return SW'($urandom);
        if (pick < 6)
            return SW'($signed($urandom_range(0, 2000)) - 1000);
        if (gain_shadow == 0)
            return SW'($urandom);
        comp = (level_shadow * {33'd0, HALF_PI_Q30} + 64'd8192) >> COMP_SHIFT;
        mag = comp / gain_shadow + 64'($urandom_range(0, 4)) - 64'd2;
        if (mag > (64'd1 << (SW - 1)) - 1)
            mag = (64'd1 << (SW - 1)) - 1;
        return $urandom_range(0, 1) ? SW'(64'd0 - mag) : mag[SW-1:0];
    endfunction

    stim_row_t directed_rows[9] = '{
        '{24'h000000, 1'b0, 1'b1, 24'h000000},
        '{24'h7FFFFF, 1'b1, 1'b0, 24'h000000},
        '{24'h800000, 1'b0, 1'b0, 24'h000000},
        '{24'h000001, 1'b1, 1'b0, 24'h000000},
        '{24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
        '{24'h555555, 1'b0, 1'b0, 24'h000000},
        '{24'hAAAAAA, 1'b1, 1'b0, 24'h000000},
        '{24'h400000, 1'b0, 1'b0, 24'h000000},
        '{24'hC00000, 1'b1, 1'b0, 24'h000000}
    };

    // Main sequence: directed table, then register settings with random samples
    initial
    begin
        logic [31:0] gains[7];
        logic [31:0] levels[7];
        int          ph;
        int          n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        cycle_count = 0;
        no_stalls = 1'b0;
        gain_shadow = {40'd0, GAIN_RESET};
        level_shadow = (64'd1 << (SW - 1)) - 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings
        foreach (directed_rows[i])
            send_request(directed_rows[i].sample, directed_rows[i].last,
                         directed_rows[i].known, directed_rows[i].shaped);
        drain();

        // Settings: unity, full gain, zero gain, smallest level, wide writes
        // (upper bits dropped, level becomes zero), and two random settings
        gains = '{32'h0001_0000, 32'h00FF_FFFF, 32'h0000_0000, 32'h0000_0001,
                  32'hAB01_2345, 32'($urandom_range(0, 24'hFFFFFF)),
                  32'($urandom_range(24'h8000, 24'h80000))};
        levels = '{32'h007F_FFFF, 32'h007F_FFFF, 32'h0000_1000, 32'h0000_0001,
                   32'hFF80_0000, 32'($urandom_range(1, 23'h7FFFFF)),
                   32'($urandom_range(1, 23'h7FFFFF))};
        for (ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_GAIN, gains[ph]);
            write_reg(REG_LEVEL, levels[ph]);
            no_stalls = (ph == 1);
            send_request(24'h7FFFFF, 1'b0, 1'b0, '0);
            send_request(24'h800000, 1'b1, 1'b0, '0);
            for (n = 0; n < 82; n++)
                send_request(random_sample(), 1'($urandom), 1'b0, '0);
            drain();
        end

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
